FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lalc_pkg.sv
package lalc_pkg;

    localparam int CNT_W            = 16;
    localparam int LUX_W            = 20;
    localparam int CH_W             = 25;   // scaled channel: count times at most 468.5
    localparam int S_TDATA_W        = 32;
    localparam int M_TDATA_W        = 24;
    localparam int SEGMENTS         = 7;
    localparam int TAB_W            = 10;
    localparam int TABLE_RATIO_BITS = 9;
    localparam int TABLE_LUX_BITS   = 14;

    localparam logic [LUX_W-1:0] LUX_MAX = 20'hFFFFF;

    localparam logic [1:0] INTEG_13MS  = 2'd0;
    localparam logic [1:0] INTEG_101MS = 2'd1;

    typedef enum logic [1:0] {
        REG_GAIN_HIGH   = 2'd0,
        REG_INTEGRATION = 2'd1,
        REG_PACKAGE     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic       gain_high;
        logic [1:0] integration_select;
        logic       package_cs;
    } cfg_t;

    // Row 0: T package, row 1: CS package
    localparam logic [TAB_W-1:0] SEG_K [2][SEGMENTS] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
    };
    localparam logic [TAB_W-1:0] SEG_B [2][SEGMENTS] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}
    };
    localparam logic [TAB_W-1:0] SEG_M [2][SEGMENTS] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b}
    };

    // ratio * 2^9 <= k * 2^rfb  <=>  ratio <= floor(k * 2^rfb / 2^9)
    function automatic logic [63:0] ratio_threshold(input logic [TAB_W-1:0] k, input int rfb);
        return (64'(k) << rfb) >> TABLE_RATIO_BITS;
    endfunction

    function automatic logic [63:0] rescale_coef(input logic [TAB_W-1:0] c, input int lfb);
        return ((64'(c) << lfb) + (64'd1 << (TABLE_LUX_BITS - 1))) >> TABLE_LUX_BITS;
    endfunction

endpackage

FILE: hw/rtl/lalc_scale.sv
module lalc_scale
    import lalc_pkg::*;
#(
    parameter int CHANNEL_SCALE_BITS = 10
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  cfg_t            cfg,
    input  logic            in_valid,
    input  logic [CNT_W-1:0] broadband_count,
    input  logic [CNT_W-1:0] infrared_count,
    output logic            out_valid,
    output logic [CH_W-1:0] ch0,
    output logic [CH_W-1:0] ch1
);

    localparam int SCALE_W = CHANNEL_SCALE_BITS + 9;
    localparam int ONE     = 1 << CHANNEL_SCALE_BITS;
    localparam int S13     = (644 * ONE + 11) / 22;
    localparam int S101    = (644 * ONE + 81) / 162;

    logic [SCALE_W-1:0]       base;
    logic [SCALE_W-1:0]       scale;
    logic [CNT_W+SCALE_W-1:0] prod0;
    logic [CNT_W+SCALE_W-1:0] prod1;
    logic [CH_W-1:0]          ch0_next;
    logic [CH_W-1:0]          ch1_next;
    logic [CH_W-1:0]          ch0_reg;
    logic [CH_W-1:0]          ch1_reg;
    logic                     valid_reg;

    always_comb
    begin
        unique case (cfg.integration_select)
            INTEG_13MS:  base = SCALE_W'(S13);
            INTEG_101MS: base = SCALE_W'(S101);
            default:     base = SCALE_W'(ONE);
        endcase
        // 1x gain: raise the scale by 16
        scale    = cfg.gain_high ? base : (base << 4);
        prod0    = broadband_count * scale;
        prod1    = infrared_count * scale;
        ch0_next = prod0[CHANNEL_SCALE_BITS +: CH_W];
        ch1_next = prod1[CHANNEL_SCALE_BITS +: CH_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ch0_reg <= ch0_next;
            ch1_reg <= ch1_next;
        end
    end

    assign out_valid = valid_reg;
    assign ch0       = ch0_reg;
    assign ch1       = ch1_reg;

endmodule

FILE: hw/rtl/lalc_div_stage.sv
module lalc_div_stage
    import lalc_pkg::*;
#(
    parameter int Q_W = 35
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [CH_W-1:0] rem_in,
    input  logic [Q_W-1:0]  work_in,    // dividend bits high, quotient bits low
    input  logic [CH_W-1:0] div_in,
    input  logic [CH_W-1:0] ch1_in,
    output logic            out_valid,
    output logic [CH_W-1:0] rem_out,
    output logic [Q_W-1:0]  work_out,
    output logic [CH_W-1:0] div_out,
    output logic [CH_W-1:0] ch1_out
);

    logic [CH_W:0]   trial;
    logic [CH_W:0]   diff;
    logic            ge;
    logic [CH_W-1:0] rem_next;
    logic [Q_W-1:0]  work_next;
    logic [CH_W-1:0] rem_reg;
    logic [Q_W-1:0]  work_reg;
    logic [CH_W-1:0] div_reg;
    logic [CH_W-1:0] ch1_reg;
    logic            valid_reg;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {rem_in, work_in[Q_W-1]};
        diff      = trial - {1'b0, div_in};
        ge        = (trial >= {1'b0, div_in});
        rem_next  = ge ? diff[CH_W-1:0] : trial[CH_W-1:0];
        work_next = {work_in[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
            div_reg  <= div_in;
            ch1_reg  <= ch1_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign work_out  = work_reg;
    assign div_out   = div_reg;
    assign ch1_out   = ch1_reg;

endmodule

FILE: hw/rtl/lalc_lux.sv
`include "assert_macros.svh"

module lalc_lux
    import lalc_pkg::*;
#(
    parameter int RATIO_FRACTION_BITS = 9,
    parameter int LUX_FRACTION_BITS   = 14,
    parameter int Q_W                 = 35
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  logic [Q_W-1:0]   quotient,
    input  logic [CH_W-1:0]  ch0,
    input  logic [CH_W-1:0]  ch1,
    output logic             out_valid,
    output logic [LUX_W-1:0] lux
);

    localparam int COEF_W = (LUX_FRACTION_BITS > TABLE_LUX_BITS) ? LUX_FRACTION_BITS - 3 : 11;
    localparam int PROD_W = CH_W + COEF_W;
    localparam int FULL_W = PROD_W + 1 - LUX_FRACTION_BITS;

    logic [4:0]              vld_reg;

    // ratio stage
    logic [Q_W:0]            ratio_sum;
    logic [Q_W-1:0]          ratio_next;
    logic [Q_W-1:0]          ratio_reg;
    logic [CH_W-1:0]         ch0_r1_reg;
    logic [CH_W-1:0]         ch1_r1_reg;

    // segment stage
    logic [COEF_W-1:0]       b_next;
    logic [COEF_W-1:0]       m_next;
    logic [COEF_W-1:0]       b_reg;
    logic [COEF_W-1:0]       m_reg;
    logic [CH_W-1:0]         ch0_r2_reg;
    logic [CH_W-1:0]         ch1_r2_reg;

    // product, difference and rounding stages
    logic [PROD_W-1:0]       pos_next;
    logic [PROD_W-1:0]       neg_next;
    logic [PROD_W-1:0]       pos_reg;
    logic [PROD_W-1:0]       neg_reg;
    logic [PROD_W-1:0]       diff_next;
    logic [PROD_W-1:0]       diff_reg;
    logic [PROD_W:0]         round_sum;
    logic [FULL_W-1:0]       lux_full;
    logic [LUX_W-1:0]        lux_next;
    logic [LUX_W-1:0]        lux_reg;

    always_comb
    begin
        ratio_sum  = {1'b0, quotient} + (Q_W+1)'(1);
        ratio_next = (ch0 == '0) ? '0 : ratio_sum[Q_W:1];
    end

    // First segment whose breakpoint the ratio does not pass; none leaves zero
    always_comb
    begin
        logic found;
        found  = 1'b0;
        b_next = '0;
        m_next = '0;
        for (int i = 0; i < SEGMENTS; i++)
        begin
            if (!found && (64'(ratio_reg)
                    <= ratio_threshold(SEG_K[cfg.package_cs][i], RATIO_FRACTION_BITS)))
            begin
                found  = 1'b1;
                b_next = COEF_W'(rescale_coef(SEG_B[cfg.package_cs][i], LUX_FRACTION_BITS));
                m_next = COEF_W'(rescale_coef(SEG_M[cfg.package_cs][i], LUX_FRACTION_BITS));
            end
        end
    end

    always_comb
    begin
        pos_next  = ch0_r2_reg * b_reg;
        neg_next  = ch1_r2_reg * m_reg;
        // clamp a negative difference to zero
        diff_next = (pos_reg > neg_reg) ? (pos_reg - neg_reg) : '0;
        round_sum = {1'b0, diff_reg} + ((PROD_W+1)'(1) << (LUX_FRACTION_BITS - 1));
        lux_full  = round_sum[PROD_W:LUX_FRACTION_BITS];
        lux_next  = (lux_full > FULL_W'(LUX_MAX)) ? LUX_MAX : lux_full[LUX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ratio_reg  <= ratio_next;
            ch0_r1_reg <= ch0;
            ch1_r1_reg <= ch1;
            b_reg      <= b_next;
            m_reg      <= m_next;
            ch0_r2_reg <= ch0_r1_reg;
            ch1_r2_reg <= ch1_r1_reg;
            pos_reg    <= pos_next;
            neg_reg    <= neg_next;
            diff_reg   <= diff_next;
            lux_reg    <= lux_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign lux       = lux_reg;

    `ASSERT_NEXT(a_zero_diff_zero_lux, clk, rst_n,
        en && vld_reg[3] && (diff_reg == '0), lux_reg == '0,
        "nonzero lux from zero difference")

endmodule

FILE: hw/rtl/ambient_light_lux_calculator.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  broadband_count, infrared_count
// m_*       out  m_tvalid/m_tready  lux
// cfg_*     in   cfg_wr_en          register index, write data
//
// One item per cycle unless the pipeline holds. Most of the latency comes from
// the one-bit-per-stage divider that forms the IR/broadband ratio.
// Reset clears the valid bits and loads the register defaults (CS package).
// The pipeline holds only while the output register is full and not taken and the
// last stage carries an item; otherwise all stages advance, filling that stage.
`include "assert_macros.svh"

module ambient_light_lux_calculator
    import lalc_pkg::*;
#(
    parameter int CHANNEL_SCALE_BITS  = 10,
    parameter int RATIO_FRACTION_BITS = 9,
    parameter int LUX_FRACTION_BITS   = 14
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] broadband_count, [31:16] infrared_count
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [19:0] lux, [23:20] zero
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [1:0]           cfg_data
);

    localparam int Q_W = CH_W + RATIO_FRACTION_BITS + 1;

    cfg_t             cfg_reg;
    logic             en;
    logic             scale_vld;
    logic [CH_W-1:0]  scale_ch0;
    logic [CH_W-1:0]  scale_ch1;
    logic [Q_W:0]     dvld;
    logic [CH_W-1:0]  drem  [Q_W+1];
    logic [Q_W-1:0]   dwork [Q_W+1];
    logic [CH_W-1:0]  ddiv  [Q_W+1];
    logic [CH_W-1:0]  dch1  [Q_W+1];
    logic             lux_vld;
    logic [LUX_W-1:0] lux_out;
    logic             m_tvalid_reg;
    logic [LUX_W-1:0] lux_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_high          <= 1'b0;
            cfg_reg.integration_select <= INTEG_13MS;
            cfg_reg.package_cs         <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_HIGH:   cfg_reg.gain_high          <= cfg_data[0];
                REG_INTEGRATION: cfg_reg.integration_select <= cfg_data;
                REG_PACKAGE:     cfg_reg.package_cs         <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Stall only when a finished item has nowhere to go
    assign en       = !m_tvalid_reg || m_tready || !lux_vld;
    assign s_tready = en;

    lalc_scale #(
        .CHANNEL_SCALE_BITS (CHANNEL_SCALE_BITS)
    ) u_scale (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .cfg             (cfg_reg),
        .in_valid        (s_tvalid),
        .broadband_count (s_tdata[CNT_W-1:0]),
        .infrared_count  (s_tdata[2*CNT_W-1:CNT_W]),
        .out_valid       (scale_vld),
        .ch0             (scale_ch0),
        .ch1             (scale_ch1)
    );

    assign dvld[0]  = scale_vld;
    assign drem[0]  = '0;
    assign dwork[0] = {scale_ch1, {(RATIO_FRACTION_BITS + 1){1'b0}}};
    assign ddiv[0]  = scale_ch0;
    assign dch1[0]  = scale_ch1;

    for (genvar g = 0; g < Q_W; g++)
    begin : g_div
        lalc_div_stage #(
            .Q_W (Q_W)
        ) u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dvld[g]),
            .rem_in    (drem[g]),
            .work_in   (dwork[g]),
            .div_in    (ddiv[g]),
            .ch1_in    (dch1[g]),
            .out_valid (dvld[g+1]),
            .rem_out   (drem[g+1]),
            .work_out  (dwork[g+1]),
            .div_out   (ddiv[g+1]),
            .ch1_out   (dch1[g+1])
        );
    end

    lalc_lux #(
        .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS),
        .LUX_FRACTION_BITS   (LUX_FRACTION_BITS),
        .Q_W                 (Q_W)
    ) u_lux (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (dvld[Q_W]),
        .quotient  (dwork[Q_W]),
        .ch0       (ddiv[Q_W]),
        .ch1       (dch1[Q_W]),
        .out_valid (lux_vld),
        .lux       (lux_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (!m_tvalid_reg || m_tready)
        begin
            m_tvalid_reg <= lux_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!m_tvalid_reg || m_tready) && lux_vld)
        begin
            lux_reg <= lux_out;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - LUX_W){1'b0}}, lux_reg};

    `ASSERT_NEXT(a_accept_enters, clk, rst_n,
        s_tvalid && s_tready, scale_vld,
        "accepted item missing from first stage")
    `ASSERT_IMPLY(a_div_rem_bound, clk, rst_n,
        dvld[Q_W] && (ddiv[Q_W] != '0), drem[Q_W] < ddiv[Q_W],
        "divider remainder not below divisor")

endmodule

FILE: test/ambient_light_lux_calculator_tb.sv
module ambient_light_lux_calculator_tb;
    import lalc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_FRAC    = 10;
    localparam int RATIO_FRAC = 9;
    localparam int LUX_FRAC   = 14;
    localparam int LATENCY    = RATIO_FRAC + 33;

    localparam logic [1:0] INTEG_402MS = 2'd2;
    localparam logic [1:0] INTEG_SEL3  = 2'd3;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int N_PHASES        = 7;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 300;

    localparam int SRC_IDLE [4]   = '{0, 76, 0, 6};
    localparam int SINK_STALL [4] = '{0, 0, 76, 6};

    // Piecewise segments: ratio knee, lux offset, lux slope. Row 0 T, row 1 CS.
    localparam logic [9:0] RATIO_KNEE [2][SEGMENTS] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
    };
    localparam logic [9:0] LUX_OFFSET [2][SEGMENTS] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037}
    };
    localparam logic [9:0] LUX_SLOPE [2][SEGMENTS] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b}
    };

    localparam cfg_t RESET_CFG = '{1'b0, INTEG_13MS, 1'b1};

    typedef struct packed {
        cfg_t        cfg;
        logic [15:0] bb;
        logic [15:0] ir;
        logic        known;
        logic [19:0] lux;
    } probe_row_t;

    localparam int N_PROBES = 25;
    localparam probe_row_t PROBES [N_PROBES] = '{
        '{'{1'b0, INTEG_13MS, 1'b1},  16'h0000, 16'h0000, 1'b1, 20'd0},
        '{'{1'b0, INTEG_13MS, 1'b1},  16'h0000, 16'hffff, 1'b1, 20'd0},
        '{'{1'b0, INTEG_13MS, 1'b1},  16'hffff, 16'h0000, 1'b0, 20'd0},
        '{'{1'b0, INTEG_13MS, 1'b1},  16'h0001, 16'hffff, 1'b1, 20'd0},
        '{'{1'b0, INTEG_13MS, 1'b1},  16'hffff, 16'hffff, 1'b0, 20'd0},
        '{'{1'b0, INTEG_13MS, 1'b1},  16'h8000, 16'h4000, 1'b0, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b1}, 16'h4000, 16'h0000, 1'b1, 20'd516},
        '{'{1'b1, INTEG_402MS, 1'b1}, 16'h0001, 16'h0000, 1'b1, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b1}, 16'h0200, 16'h0043, 1'b0, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b1}, 16'h0200, 16'h0044, 1'b0, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b1}, 16'h0200, 16'h010a, 1'b0, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b1}, 16'h0200, 16'h010b, 1'b0, 20'd0},
        // last knee exactly: slope term exceeds offset term, clamp to zero
        '{'{1'b1, INTEG_402MS, 1'b1}, 16'h0200, 16'h029a, 1'b1, 20'd0},
        // one past the last knee: no segment applies
        '{'{1'b1, INTEG_402MS, 1'b1}, 16'h0200, 16'h029b, 1'b1, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b0}, 16'h4000, 16'h0000, 1'b1, 20'd498},
        '{'{1'b1, INTEG_402MS, 1'b0}, 16'h0200, 16'h0040, 1'b0, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b0}, 16'h0200, 16'h0041, 1'b0, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b0}, 16'h0200, 16'h0138, 1'b0, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b0}, 16'h0200, 16'h0139, 1'b0, 20'd0},
        '{'{1'b1, INTEG_402MS, 1'b0}, 16'h0200, 16'h029b, 1'b1, 20'd0},
        '{'{1'b0, INTEG_101MS, 1'b1}, 16'hffff, 16'h8000, 1'b0, 20'd0},
        '{'{1'b1, INTEG_13MS, 1'b0},  16'h1234, 16'h0567, 1'b0, 20'd0},
        '{'{1'b1, INTEG_SEL3, 1'b1},  16'h4000, 16'h0000, 1'b1, 20'd516},
        '{'{1'b0, INTEG_402MS, 1'b0}, 16'h0400, 16'h0000, 1'b1, 20'd498},
        '{'{1'b0, INTEG_13MS, 1'b0},  16'hffff, 16'h0000, 1'b0, 20'd0}
    };

    localparam cfg_t PHASE_CFG [N_PHASES] = '{
        '{1'b0, INTEG_13MS, 1'b1},
        '{1'b1, INTEG_402MS, 1'b0},
        '{1'b0, INTEG_101MS, 1'b0},
        '{1'b1, INTEG_13MS, 1'b1},
        '{1'b0, INTEG_402MS, 1'b1},
        '{1'b1, INTEG_101MS, 1'b0},
        '{1'b1, INTEG_SEL3, 1'b1}
    };

    typedef struct {
        logic [15:0] bb;
        logic [15:0] ir;
        logic [19:0] lux;
    } lux_expect_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_index = REG_GAIN_HIGH;
    logic [1:0]           cfg_data  = 2'd0;

    lux_expect_t pending_lux [$];
    cfg_t        cur_cfg        = RESET_CFG;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    logic        hold_req       = 1'b0;
    logic        hold_done      = 1'b0;
    int          errors         = 0;
    int          samples_sent   = 0;
    int          lux_checked    = 0;
    int          cfg_settings   = 1;

    ambient_light_lux_calculator #(
        .CHANNEL_SCALE_BITS  (CH_FRAC),
        .RATIO_FRACTION_BITS (RATIO_FRAC),
        .LUX_FRACTION_BITS   (LUX_FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic [63:0] coef_at_lux_frac(input logic [9:0] c);
        return ((64'(c) << LUX_FRAC) + (64'd1 << (TABLE_LUX_BITS - 1))) >> TABLE_LUX_BITS;
    endfunction

    function automatic logic [19:0] predict_lux(input cfg_t c, input logic [15:0] bb,
                                                input logic [15:0] ir);
        logic [63:0] one;
        logic [63:0] scale;
        logic [63:0] ch0;
        logic [63:0] ch1;
        logic [63:0] quot;
        logic [63:0] ratio;
        logic [63:0] ofs;
        logic [63:0] slp;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] lx;
        int          seg;
        one = 64'd1 << CH_FRAC;
        case (c.integration_select)
            INTEG_13MS:  scale = (64'd322 * one * 64'd2 + 64'd11) / 64'd22;
            INTEG_101MS: scale = (64'd322 * one * 64'd2 + 64'd81) / 64'd162;
            default:     scale = one;
        endcase
        if (!c.gain_high)
            scale = scale << 4;
        ch0 = (64'(bb) * scale) >> CH_FRAC;
        ch1 = (64'(ir) * scale) >> CH_FRAC;
        quot = 64'd0;
        if (ch0 != 64'd0)
            quot = (ch1 << (RATIO_FRAC + 1)) / ch0;
        ratio = (quot + 64'd1) >> 1;
        ofs = 64'd0;
        slp = 64'd0;
        // walk from the top so the lowest matching segment wins
        for (seg = SEGMENTS - 1; seg >= 0; seg--)
        begin
            if ((ratio << TABLE_RATIO_BITS) <=
                (64'(RATIO_KNEE[c.package_cs][seg]) << RATIO_FRAC))
            begin
                ofs = coef_at_lux_frac(LUX_OFFSET[c.package_cs][seg]);
                slp = coef_at_lux_frac(LUX_SLOPE[c.package_cs][seg]);
            end
        end
        pos = ch0 * ofs;
        neg = ch1 * slp;
        if (pos <= neg)
            lx = 64'd0;
        else
            lx = ((pos - neg) + (64'd1 << (LUX_FRAC - 1))) >> LUX_FRAC;
        if (lx > 64'(LUX_MAX))
            lx = 64'(LUX_MAX);
        return lx[19:0];
    endfunction

    // Offer one sample and hold it until taken; record what should come out.
    task automatic push_sample(input logic [15:0] bb, input logic [15:0] ir,
                               input logic known, input logic [19:0] known_lux);
        lux_expect_t e;
        logic        taken;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ir, bb};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        e.bb  = bb;
        e.ir  = ir;
        e.lux = known ? known_lux : predict_lux(cur_cfg, bb, ir);
        pending_lux.insert(pending_lux.size(), e);
        samples_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_lux.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_cfg(input cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GAIN_HIGH;
        cfg_data  <= {1'b0, c.gain_high};
        @(posedge clk);
        cfg_index <= REG_INTEGRATION;
        cfg_data  <= c.integration_select;
        @(posedge clk);
        cfg_index <= REG_PACKAGE;
        cfg_data  <= {1'b0, c.package_cs};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
        cfg_settings++;
    endtask

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #4_000_000;
        $display("%0t: timeout, %0d lux results still pending", $time, pending_lux.size());
        $display("FAIL");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off to back the pipeline up.
    initial
    begin : output_sink
        int hold_cnt;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Sample at the falling edge: the item moves at the next rising edge.
    always @(negedge clk)
    begin : lux_monitor
        lux_expect_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_lux.size() == 0)
            begin
                errors++;
                $display("%0t: lux item with nothing pending: expected none, actual %h",
                         $time, m_tdata);
            end
            else
            begin
                e = pending_lux.pop_front();
                lux_checked++;
                if (m_tdata !== M_TDATA_W'(e.lux))
                begin
                    errors++;
                    $display("%0t: lux mismatch bb=%h ir=%h: expected %h, actual %h",
                             $time, e.bb, e.ir, M_TDATA_W'(e.lux), m_tdata);
                end
            end
        end
    end

    initial
    begin : stimulus
        int          row;
        int          ph;
        int          n;
        int          prod;
        logic [15:0] bb;
        logic [15:0] ir;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < N_PROBES; row++)
        begin
            if (PROBES[row].cfg != cur_cfg)
            begin
                wait_for_results();
                apply_cfg(PROBES[row].cfg);
            end
            push_sample(PROBES[row].bb, PROBES[row].ir, PROBES[row].known, PROBES[row].lux);
        end

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            wait_for_results();
            apply_cfg(PHASE_CFG[ph]);
            src_idle_pct   = SRC_IDLE[ph % 4];
            sink_stall_pct = SINK_STALL[ph % 4];
            if (ph == PRESSURE_PHASE)
                hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        bb = 16'($urandom);
                        ir = 16'($urandom);
                    end
                    1:
                    begin
                        // steer the ratio across every segment and past the last knee
                        bb   = 16'($urandom_range(65535, 1));
                        prod = (int'(bb) * int'($urandom_range(720, 0))) >> 9;
                        ir   = (prod > 65535) ? 16'hffff : prod[15:0];
                    end
                    2:
                    begin
                        bb = 16'($urandom_range(255, 0));
                        ir = 16'($urandom_range(255, 0));
                    end
                    default:
                    begin
                        bb = $urandom_range(1) ? 16'hffff : 16'($urandom);
                        ir = $urandom_range(1) ? 16'h0000 : 16'($urandom);
                    end
                endcase
                push_sample(bb, ir, 1'b0, 20'd0);
            end
        end

        wait_for_results();
        repeat (2 * LATENCY) @(posedge clk);
        if (pending_lux.size() != 0)
        begin
            errors++;
            $display("%0t: lux items missing: expected %0d more, actual none",
                     $time, pending_lux.size());
        end

        $display("Checked %0d lux results from %0d samples across %0d register settings,",
                 lux_checked, samples_sent, cfg_settings);
        $display("with segment knees, zero broadband, clamping and a backed-up output.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
